// ===== rtl/core/setc_pkg.sv =====
// Shared types and constants for the scope edge trigger capture block.
// Holds the transfer structs, register and operation codes, and the
// controller/datapath command and status bundles. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package setc_pkg;

    // Defaults for the top-level parameters. RING_DEPTH must be a power of two.
    localparam int RING_DEPTH_DEF  = 2048;
    localparam int SAMPLE_BITS_DEF = 10;

    // Field widths of the transfers
    localparam int IN_SAMPLE_BITS = 10;
    localparam int IDX_BITS       = 11;
    localparam int TALLY_BITS     = 32;
    localparam int LEVEL_BITS     = 10;
    localparam int SPAN_BITS      = 12;
    localparam int CMP_BITS       = 16;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_LEVEL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_FALLING  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SEARCH_SPAN   = 2'd2;

    localparam logic [LEVEL_BITS-1:0] LEVEL_RST = 10'd512;
    localparam logic [SPAN_BITS-1:0]  SPAN_RST  = 12'd128;

    // Item operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                      opcode;
        logic [IN_SAMPLE_BITS-1:0] sample;
        logic                      fifo_overflow;
    } t_item;

    typedef struct packed {
        logic [IDX_BITS-1:0]   trigger_index;
        logic                  trigger_found;
        logic [TALLY_BITS-1:0] search_failures;
        logic [TALLY_BITS-1:0] overflow_errors;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic clr_we;   // write one zero word of the clearing pass
        logic store;    // store the incoming sample
        logic load;     // load the search start position
        logic rd;       // issue a ring read and step the read address back
        logic shift;    // move the returned word into the current-sample register
        logic test;     // a crossing test is valid this cycle
        logic finish;   // close the search and present the result
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic hit;
        logic last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/core/scope_edge_trigger_capture.sv =====
// Scope edge trigger capture: ring of ADC samples with a backward edge search.
// A sample item is stored on its transfer and gives no result, so a converter can
// stream one sample per clock while busy is low. A search item making n
// crossing tests (1 to RING_DEPTH/2+1) holds busy high after the start
// transfer: one ring read per cycle through the single read port, the
// PRIME0 and PRIME1 states to fill the sample pair, then one test per cycle.
// The result appears on o_result with o_res_strobe, high for a single cycle,
// in the first cycle with busy low again; it cannot be held off, so latch it on
// the strobe. After reset the ring is zeroed by a clearing pass over all
// RING_DEPTH slots with busy high; configuration writes are taken at any
// time, but change them only while no search is in flight. RING_DEPTH must
// be a power of two.
// Depends on setc_pkg, setc_ctrl, setc_datapath.
`timescale 1ns / 1ps
`default_nettype none

module scope_edge_trigger_capture
    import setc_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Item transfer
    input  wire logic                     start,
    output logic                          busy,
    input  wire t_item                    i_item,
    // Result transfer
    output logic                          o_res_strobe,
    output t_result                       o_result,
    // Configuration write channel
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Register writes never stall, so the channel is always ready
    assign o_cfg_ready = 1'b1;

    setc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_item.opcode),
        .i_stat   (dp_stat),
        .o_busy   (busy),
        .o_cmd    (dp_cmd)
    );

    setc_datapath #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_valid & o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/setc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the sample ring. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module setc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/setc_ctrl.sv =====
// Controller state machine for the edge trigger capture block.
// Sequences the clearing pass, sample stores and the backward search.
// Depends on setc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module setc_ctrl
    import setc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire logic     i_opcode,
    input  wire t_dp_stat i_stat,
    output logic          o_busy,
    output t_dp_cmd       o_cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_PRIME0 = 3'd2;
    localparam logic [2:0] ST_PRIME1 = 3'd3;
    localparam logic [2:0] ST_WALK   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_opcode == OP_SEARCH) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_PRIME0;
                    end else begin
                        o_cmd.store = 1'b1;
                    end
                end
            end
            ST_PRIME0: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_PRIME1;
            end
            ST_PRIME1: begin
                o_cmd.rd    = 1'b1;
                o_cmd.shift = 1'b1;
                n_state     = ST_WALK;
            end
            ST_WALK: begin
                o_cmd.rd    = 1'b1;
                o_cmd.shift = 1'b1;
                o_cmd.test  = 1'b1;
                if (i_stat.hit || i_stat.last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/setc_datapath.sv =====
// Datapath: sample ring, write pointer, tallies, configuration registers
// and the crossing comparator. Depends on setc_pkg and setc_ram.
`timescale 1ns / 1ps
`default_nettype none

module setc_datapath
    import setc_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_stat                      o_stat,
    input  wire t_item                    i_item,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                          o_res_strobe,
    output t_result                       o_result
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] HALF = AW'(RING_DEPTH / 2);
    localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

    // Control state
    logic [AW-1:0]         r_newest;
    logic [AW-1:0]         r_clr;
    logic [AW-1:0]         r_k;
    logic [TALLY_BITS-1:0] r_fail;
    logic [TALLY_BITS-1:0] r_ovf;
    logic [LEVEL_BITS-1:0] r_level;
    logic                  r_falling;
    logic [SPAN_BITS-1:0]  r_span;
    logic                  r_res_strobe;

    // Payload
    logic [AW-1:0]          r_addr;
    logic [AW-1:0]          r_cand;
    logic [SAMPLE_BITS-1:0] r_cur;
    logic [IDX_BITS-1:0]    r_res_idx;
    logic                   r_res_found;

    logic [31:0]            off32;
    logic [AW-1:0]          start_idx;
    logic [AW-1:0]          fallback;
    logic [AW-1:0]          next_slot;
    logic [31:0]            sample32;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [CMP_BITS-1:0]    cur_c;
    logic [CMP_BITS-1:0]    prev_c;
    logic [CMP_BITS-1:0]    lvl_c;
    logic                   hit;

    assign off32     = 32'(r_span >> 1);
    assign start_idx = r_newest - off32[AW-1:0];
    assign fallback  = r_newest - HALF;
    assign next_slot = r_newest + AW'(1);
    assign sample32  = 32'(i_item.sample);

    assign ram_we    = i_cmd.clr_we | i_cmd.store;
    assign ram_waddr = i_cmd.clr_we ? r_clr : next_slot;
    assign ram_wdata = i_cmd.clr_we ? '0 : sample32[SAMPLE_BITS-1:0];

    setc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // r_cur holds the candidate slot, the RAM output holds the slot before it
    assign cur_c  = CMP_BITS'(r_cur);
    assign prev_c = CMP_BITS'(ram_rdata);
    assign lvl_c  = CMP_BITS'(r_level);
    assign hit    = r_falling ? (cur_c <= lvl_c && prev_c > lvl_c)
                              : (cur_c >= lvl_c && prev_c < lvl_c);

    assign o_stat.clr_last = (r_clr == LAST);
    assign o_stat.hit      = hit;
    assign o_stat.last     = (r_k == HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest     <= LAST;
            r_clr        <= '0;
            r_k          <= '0;
            r_fail       <= '0;
            r_ovf        <= '0;
            r_level      <= LEVEL_RST;
            r_falling    <= 1'b0;
            r_span       <= SPAN_RST;
            r_res_strobe <= 1'b0;
        end else begin
            r_res_strobe <= i_cmd.finish;
            if (i_cmd.clr_we) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.store) begin
                r_newest <= next_slot;
                if (i_item.fifo_overflow) begin
                    r_ovf <= r_ovf + TALLY_BITS'(1);
                end
            end
            if (i_cmd.load) begin
                r_k <= '0;
            end else if (i_cmd.test) begin
                r_k <= r_k + AW'(1);
            end
            if (i_cmd.finish && !hit) begin
                r_fail <= r_fail + TALLY_BITS'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TRIGGER_LEVEL: r_level   <= i_cfg_data[LEVEL_BITS-1:0];
                    CFG_EDGE_FALLING:  r_falling <= i_cfg_data[0];
                    CFG_SEARCH_SPAN:   r_span    <= i_cfg_data[SPAN_BITS-1:0];
                    default: begin
                        // drop writes to unused indexes
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= start_idx;
            r_cand <= start_idx;
        end else begin
            if (i_cmd.rd) begin
                r_addr <= r_addr - AW'(1);
            end
            if (i_cmd.test) begin
                r_cand <= r_cand - AW'(1);
            end
        end
        if (i_cmd.shift) begin
            r_cur <= ram_rdata;
        end
        if (i_cmd.finish) begin
            r_res_idx   <= hit ? IDX_BITS'(r_cand) : IDX_BITS'(fallback);
            r_res_found <= hit;
        end
    end

    assign o_res_strobe             = r_res_strobe;
    assign o_result.trigger_index   = r_res_idx;
    assign o_result.trigger_found   = r_res_found;
    assign o_result.search_failures = r_fail;
    assign o_result.overflow_errors = r_ovf;

endmodule

`default_nettype wire

// ===== rtl/core/setc_checker.sv =====
// Port-level checks for scope_edge_trigger_capture, bound to the top level.
// Depends on setc_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module setc_checker
    import setc_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire t_item   i_item,
    input wire logic    o_res_strobe,
    input wire t_result o_result
);

    // A search always passes through the prime and walk states, so strobes never touch
    a_strobe_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |=> !o_res_strobe)
        else $error("result strobes in back-to-back cycles");

    // An accepted search holds the item port off
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.opcode == OP_SEARCH) |=> busy)
        else $error("busy low after a search transfer");

    // A sample transfer never stalls the next one
    a_sample_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.opcode == OP_SAMPLE) |=> !busy)
        else $error("busy raised by a sample transfer");

    // The fail tally moves only with a result, and only when nothing was found
    a_fail_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.search_failures != $past(o_result.search_failures))
            |-> (o_res_strobe && !o_result.trigger_found))
        else $error("fail tally changed without a failed search");

    a_fail_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && !o_result.trigger_found)
            |-> (o_result.search_failures
                 == $past(o_result.search_failures) + TALLY_BITS'(1)))
        else $error("failed search did not advance the fail tally by one");

endmodule

bind scope_edge_trigger_capture setc_checker u_setc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_item       (i_item),
    .o_res_strobe (o_res_strobe),
    .o_result     (o_result)
);

`default_nettype wire

// ===== sim/tb_scope_edge_trigger_capture.sv =====
// Self-checking testbench for scope_edge_trigger_capture: streams samples into the ring,
// issues edge searches under varying register settings and checks every search result.
// Depends on setc_pkg and the scope_edge_trigger_capture RTL only.
`timescale 1ns / 1ps

module tb_scope_edge_trigger_capture;
    import setc_pkg::*;

    localparam int HALF_RING       = RING_DEPTH_DEF / 2;
    localparam int SETTLE          = 4;    // quiet cycles that close a drain
    localparam int TAIL            = 20;   // cycles after the last drain
    localparam int PHASES          = 16;
    localparam int ITEMS_PER_PHASE = 80;

    // Register index that the block does not implement; writes to it are dropped.
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        JOB_ITEM,
        JOB_CFG,
        JOB_DRAIN
    } t_job_kind;

    // One entry of the driver's work list: an item transfer, a register write, or a
    // drain that holds the sender until every expected result has come back.
    typedef struct packed {
        t_job_kind                kind;
        t_item                    item;
        logic [CFG_IDX_BITS-1:0]  cfg_index;
        logic [CFG_DATA_BITS-1:0] cfg_data;
        logic [7:0]               gap;
    } t_job;

    // DUT ports; every input starts at a known value
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     start       = 1'b0;
    logic                     busy;
    t_item                    i_item      = '0;
    logic                     o_res_strobe;
    t_result                  o_result;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    // Work list and driver state
    t_job        job_q[$];
    t_job        cur_job;
    logic        have_job    = 1'b0;
    int unsigned gap_left    = 0;
    int unsigned settle_left = 0;
    logic        drv_idle    = 1'b0;

    // Shadow of the block: ring, newest slot, tallies and registers
    logic [IN_SAMPLE_BITS-1:0] ring_copy [RING_DEPTH_DEF];
    logic [IDX_BITS-1:0]       newest_copy;
    logic [TALLY_BITS-1:0]     fail_copy;
    logic [TALLY_BITS-1:0]     ovf_copy;
    logic [LEVEL_BITS-1:0]     level_copy;
    logic                      falling_copy;
    logic [SPAN_BITS-1:0]      span_copy;

    // Expected search results, oldest first, and its size as seen by the driver
    t_result     expected_triggers[$];
    int unsigned outstanding = 0;

    // Bookkeeping
    int unsigned err_cnt        = 0;
    int unsigned samples_seen   = 0;
    int unsigned flagged_seen   = 0;
    int unsigned searches_seen  = 0;
    int unsigned hits_seen      = 0;
    int unsigned fallbacks_seen = 0;
    int unsigned cfg_writes     = 0;
    longint      budget_cycles  = 0;
    longint      cycle_limit    = 64'd1 << 40;
    longint      cycle_cnt      = 0;

    scope_edge_trigger_capture dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Work list builders; each also adds its worst-case cycle cost to the budget.
    // ------------------------------------------------------------------
    task automatic push_item(input logic op, input int unsigned smp, input bit ovf,
                             input int unsigned gap);
        t_job j;
        j = '0;
        j.kind               = JOB_ITEM;
        j.item.opcode        = op;
        j.item.sample        = smp[IN_SAMPLE_BITS-1:0];
        j.item.fifo_overflow = ovf;
        j.gap                = gap[7:0];
        job_q.push_back(j);
        budget_cycles += gap + ((op == OP_SEARCH) ? HALF_RING + 8 : 2);
    endtask

    // Fill the bits above the register's field with noise; the block must drop them.
    task automatic push_cfg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned value);
        t_job                     j;
        logic [CFG_DATA_BITS-1:0] keep;
        case (idx)
            CFG_TRIGGER_LEVEL: keep = 16'h03FF;
            CFG_EDGE_FALLING:  keep = 16'h0001;
            CFG_SEARCH_SPAN:   keep = 16'h0FFF;
            default:           keep = 16'hFFFF;
        endcase
        j = '0;
        j.kind      = JOB_CFG;
        j.cfg_index = idx;
        j.cfg_data  = (value[CFG_DATA_BITS-1:0] & keep) | (16'($urandom) & ~keep);
        j.gap       = 8'($urandom_range(0, 2));
        job_q.push_back(j);
        budget_cycles += 6;
    endtask

    task automatic push_drain();
        t_job j;
        j = '0;
        j.kind = JOB_DRAIN;
        job_q.push_back(j);
        budget_cycles += SETTLE + 4;
    endtask

    // Mostly back-to-back or short gaps, now and then a long one; none in quiet phases.
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (quiet || roll >= 8)
            return 0;
        else if (roll == 0)
            return $urandom_range(10, 60);
        else if (roll < 3)
            return $urandom_range(3, 9);
        else
            return $urandom_range(1, 2);
    endfunction

    // ------------------------------------------------------------------
    // Search prediction: start span/2 behind the newest slot, walk backward for up
    // to half the ring plus one tests, fall back to half a ring behind newest.
    // ------------------------------------------------------------------
    function automatic t_result predict_trigger();
        t_result                   r;
        logic [IDX_BITS-1:0]       pos;
        logic [IDX_BITS-1:0]       prv;
        logic [IN_SAMPLE_BITS-1:0] cur;
        logic [IN_SAMPLE_BITS-1:0] prev;
        bit                        hit;
        int                        tested;
        pos    = newest_copy - IDX_BITS'(span_copy >> 1);
        hit    = 1'b0;
        tested = 0;
        while (!hit && tested <= HALF_RING) begin
            prv  = pos - 1'b1;
            cur  = ring_copy[pos];
            prev = ring_copy[prv];
            if (falling_copy)
                hit = (cur <= level_copy) && (prev > level_copy);
            else
                hit = (cur >= level_copy) && (prev < level_copy);
            if (!hit) begin
                pos    = prv;
                tested = tested + 1;
            end
        end
        if (hit) begin
            r.trigger_index = pos;
            r.trigger_found = 1'b1;
            hits_seen++;
        end else begin
            fail_copy       = fail_copy + 1'b1;
            r.trigger_index = newest_copy - IDX_BITS'(HALF_RING);
            r.trigger_found = 1'b0;
            fallbacks_seen++;
        end
        r.search_failures = fail_copy;
        r.overflow_errors = ovf_copy;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            err_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: pop jobs, honor gaps, hold start or cfg valid until the transfer,
    // and for a drain wait for an empty expectation store and a quiet block.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive
        logic nx_start;
        logic nx_cfg_valid;
        nx_start     = start;
        nx_cfg_valid = i_cfg_valid;
        if (!i_rst_n) begin
            nx_start     = 1'b0;
            nx_cfg_valid = 1'b0;
            have_job     = 1'b0;
        end else begin
            // retire whatever transferred at this edge
            if (start && !busy) begin
                nx_start = 1'b0;
                have_job = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                nx_cfg_valid = 1'b0;
                have_job     = 1'b0;
            end
            if (!have_job && job_q.size() != 0) begin
                cur_job     = job_q.pop_front();
                have_job    = 1'b1;
                gap_left    = cur_job.gap;
                settle_left = SETTLE;
            end
            if (have_job && !nx_start && !nx_cfg_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    case (cur_job.kind)
                        JOB_ITEM: begin
                            nx_start = 1'b1;
                            i_item   <= cur_job.item;
                        end
                        JOB_CFG: begin
                            nx_cfg_valid = 1'b1;
                            i_cfg_index  <= cur_job.cfg_index;
                            i_cfg_data   <= cur_job.cfg_data;
                        end
                        JOB_DRAIN: begin
                            // require several quiet cycles in a row
                            if (outstanding == 0 && !busy && !o_res_strobe) begin
                                if (settle_left == 0)
                                    have_job = 1'b0;
                                else
                                    settle_left--;
                            end else begin
                                settle_left = SETTLE;
                            end
                        end
                        default: have_job = 1'b0;
                    endcase
                end
            end
        end
        start       <= nx_start;
        i_cfg_valid <= nx_cfg_valid;
        drv_idle    <= i_rst_n && !have_job && (job_q.size() == 0);
    end

    // ------------------------------------------------------------------
    // Monitor: check results against the oldest expectation, then apply register
    // writes and item transfers to the shadow state.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : observe
        t_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < RING_DEPTH_DEF; k++)
                ring_copy[k] = '0;
            newest_copy  = IDX_BITS'(RING_DEPTH_DEF - 1);
            fail_copy    = '0;
            ovf_copy     = '0;
            level_copy   = LEVEL_RST;
            falling_copy = 1'b0;
            span_copy    = SPAN_RST;
            expected_triggers.delete();
        end else begin
            if (o_res_strobe) begin
                if (expected_triggers.size() == 0) begin
                    $display("%0t: result with none expected, got index %0d found %0b",
                             $time, o_result.trigger_index, o_result.trigger_found);
                    err_cnt++;
                end else begin
                    want = expected_triggers.pop_front();
                    check_field("trigger_index", 32'(want.trigger_index),
                                32'(o_result.trigger_index));
                    check_field("trigger_found", 32'(want.trigger_found),
                                32'(o_result.trigger_found));
                    check_field("search_failures", want.search_failures,
                                o_result.search_failures);
                    check_field("overflow_errors", want.overflow_errors,
                                o_result.overflow_errors);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                case (i_cfg_index)
                    CFG_TRIGGER_LEVEL: level_copy   = i_cfg_data[LEVEL_BITS-1:0];
                    CFG_EDGE_FALLING:  falling_copy = i_cfg_data[0];
                    CFG_SEARCH_SPAN:   span_copy    = i_cfg_data[SPAN_BITS-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (i_item.opcode == OP_SAMPLE) begin
                    samples_seen++;
                    if (i_item.fifo_overflow) begin
                        flagged_seen++;
                        ovf_copy = ovf_copy + 1'b1;
                    end
                    newest_copy            = newest_copy + 1'b1;
                    ring_copy[newest_copy] = i_item.sample;
                end else begin
                    searches_seen++;
                    expected_triggers.push_back(predict_trigger());
                end
            end
        end
        outstanding <= expected_triggers.size();
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > cycle_limit) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: a directed opening, then phases of random settings and waveforms.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          lvl;
        int          span;
        int          style;
        int          wave;
        int          ramp_step;
        int          run_left;
        int          smp;
        bit          high_side;
        bit          quiet;
        int unsigned gap;

        // Directed part, default registers: level 512, rising, span 128.
        push_drain();                          // hold until the clearing pass is done
        push_item(OP_SEARCH, 1023, 1, 0);      // zeroed ring, fallback; flag ignored
        push_item(OP_SAMPLE, 0, 0, 0);         // slot 0
        push_item(OP_SAMPLE, 1023, 1, 0);      // slot 1, flagged
        push_item(OP_SAMPLE, 511, 0, 0);       // slot 2, just below the level
        push_item(OP_SAMPLE, 512, 1, 0);       // slot 3, at the level, flagged
        push_item(OP_SEARCH, 0, 0, 0);         // start wraps below slot 0, fallback
        push_drain();
        push_cfg(CFG_SEARCH_SPAN, 0);
        push_item(OP_SEARCH, 0, 1, 0);         // rising hit exactly at the level
        push_drain();
        push_cfg(CFG_EDGE_FALLING, 1);
        push_item(OP_SEARCH, 682, 0, 0);       // falling hit one slot back
        push_drain();
        push_cfg(CFG_SEARCH_SPAN, 4);
        push_item(OP_SEARCH, 341, 1, 0);       // walk crosses slot 0 into the top slots
        push_drain();
        push_cfg(CFG_TRIGGER_LEVEL, 1023);
        push_cfg(CFG_EDGE_FALLING, 0);
        push_item(OP_SEARCH, 0, 0, 0);         // rising at the top level still hits
        push_drain();
        push_cfg(CFG_EDGE_FALLING, 1);
        push_item(OP_SEARCH, 0, 0, 0);         // falling at the top level never hits
        push_drain();
        push_cfg(CFG_TRIGGER_LEVEL, 0);
        push_item(OP_SEARCH, 0, 0, 0);         // falling at zero level
        push_drain();
        push_cfg(CFG_EDGE_FALLING, 0);
        push_item(OP_SEARCH, 0, 0, 0);         // rising at zero level never hits
        push_drain();
        push_cfg(CFG_SEARCH_SPAN, 2048);       // offset of exactly half the ring
        push_cfg(CFG_TRIGGER_LEVEL, 300);
        push_cfg(CFG_UNUSED, 16'hFFFF);        // dropped by the block
        push_item(OP_SEARCH, 0, 0, 0);
        push_drain();
        push_cfg(CFG_SEARCH_SPAN, 4095);       // offset of one slot short of a whole ring
        push_item(OP_SAMPLE, 100, 0, 0);
        push_item(OP_SAMPLE, 900, 1, 0);
        push_item(OP_SAMPLE, 200, 0, 0);
        push_item(OP_SEARCH, 0, 0, 0);

        // Random phases: drain, rewrite every register, then stream a waveform with
        // searches mixed in. Some phases run without any idling.
        for (int ph = 0; ph < PHASES; ph++) begin
            push_drain();
            case ($urandom_range(0, 5))
                0:       lvl = 0;
                1:       lvl = 1023;
                default: lvl = $urandom_range(0, 1023);
            endcase
            case ($urandom_range(0, 7))
                0:       span = 0;
                1:       span = 1;
                2:       span = 2048;
                3:       span = 4095;
                4:       span = 128;
                default: span = $urandom_range(0, 2048);
            endcase
            push_cfg(CFG_TRIGGER_LEVEL, lvl);
            push_cfg(CFG_EDGE_FALLING, $urandom_range(0, 1));
            push_cfg(CFG_SEARCH_SPAN, span);
            if ($urandom_range(0, 3) == 0)
                push_cfg(CFG_UNUSED, $urandom);
            quiet     = ($urandom_range(0, 3) == 0);
            style     = $urandom_range(0, 3);
            wave      = $urandom_range(0, 1023);
            ramp_step = $urandom_range(1, 64);
            run_left  = 0;
            high_side = 1'b0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                gap = pick_gap(quiet);
                if ($urandom_range(0, 9) == 0) begin
                    push_item(OP_SEARCH, $urandom_range(0, 1023), $urandom_range(0, 1), gap);
                end else begin
                    case (style)
                        0: smp = $urandom_range(0, 1023);          // noise
                        1: begin                                   // square around level
                            if (run_left == 0) begin
                                high_side = !high_side;
                                run_left  = $urandom_range(1, 20);
                            end
                            run_left--;
                            if (high_side)
                                smp = $urandom_range(lvl, 1023);
                            else
                                smp = (lvl == 0) ? 0 : $urandom_range(0, lvl - 1);
                        end
                        2: begin                                   // sawtooth
                            wave = (wave + ramp_step) % 1024;
                            smp  = wave;
                        end
                        default: begin                             // flat, rare jumps
                            if ($urandom_range(0, 15) == 0)
                                wave = $urandom_range(0, 1023);
                            smp = wave;
                        end
                    endcase
                    push_item(OP_SAMPLE, smp, ($urandom_range(0, 7) == 0), gap);
                end
            end
        end
        push_drain();

        // Clearing pass, every job at its worst, then a wide margin.
        cycle_limit = 4 * (budget_cycles + 2 * RING_DEPTH_DEF) + 1000;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!drv_idle)
            @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);

        if (expected_triggers.size() != 0) begin
            $display("%0t: %0d search results never arrived", $time, expected_triggers.size());
            err_cnt++;
        end
        $display("covered %0d samples (%0d flagged overflow) and %0d searches", samples_seen,
                 flagged_seen, searches_seen);
        $display("searches: %0d crossings found, %0d fallbacks; %0d register writes",
                 hits_seen, fallbacks_seen, cfg_writes);
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
